// File: rtl/assert_macros.svh
// Assertion macros shared by the list RTL.
// No dependencies; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define ILIR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an antecedent is followed in the next cycle by a consequent.
`define ILIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ILIR_ASSERT(lbl, clk, rst_n, prop, msg)
`define ILIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/ilir_pkg.sv
// Types and codes of the indexed list.
// No dependencies.
package ilir_pkg;
	localparam int WORD_W  = 32;
	localparam int INDEX_W = 4;
	localparam int COUNT_W = 5;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		FN_APPEND = 2'd0,
		FN_READ   = 2'd1,
		FN_INSERT = 2'd2,
		FN_REMOVE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_INDEX = 2'd1,
		ST_FULL  = 2'd2,
		ST_ZERO  = 2'd3
	} status_t;

	// What one cell loads at the next edge.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LOW,
		CELL_FROM_HIGH
	} cell_cmd_t;

	typedef struct packed {
		func_t              func;
		logic [INDEX_W-1:0] index;
		word_t              value;
	} req_t;

	typedef struct packed {
		word_t              value_out;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} rsp_t;
endpackage

// File: rtl/ilir_stream_if.sv
// Valid/ready channel carrying one payload of type T.
// Used with the payload structs of ilir_pkg.
interface ilir_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ilir_cell.sv
// One storage cell of the list chain: holds one word.
// Depends on ilir_pkg.
module ilir_cell (
	input  logic               clk,
	input  ilir_pkg::cell_cmd_t cmd,
	input  ilir_pkg::word_t    load_val,
	input  ilir_pkg::word_t    low_data,
	input  ilir_pkg::word_t    high_data,
	output ilir_pkg::word_t    data
);
	import ilir_pkg::*;

	word_t data_q;

	always_ff @(posedge clk) begin
		unique case (cmd)
			CELL_HOLD:      data_q <= data_q;
			CELL_LOAD:      data_q <= load_val;
			CELL_FROM_LOW:  data_q <= low_data;
			CELL_FROM_HIGH: data_q <= high_data;
		endcase
	end

	assign data = data_q;
endmodule

// File: rtl/indexed_list_insert_remove.sv
// Indexed list: each request transaction gives a registered response in the next cycle;
// one request is taken per cycle while the response side keeps up.
// Every entry lives in its own cell; insert and remove shift the whole tail in that
// same cycle, so the read mux over the first sixteen cells sets the critical path.
// Reset (arst_n low) empties the list at once; cell contents are left as they are.
module indexed_list_insert_remove #(
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic arst_n,
	ilir_stream_if.sink   req,
	ilir_stream_if.source rsp
);
	import ilir_pkg::*;

	// Length counter holds 0..DEPTH.
	localparam int LW  = $clog2(DEPTH + 1);
	// Common width to compare index, length and cell positions.
	localparam int CW  = (LW > INDEX_W) ? LW : INDEX_W;
	// Only the first sixteen cells are reachable by index.
	localparam int RN  = (DEPTH < (1 << INDEX_W)) ? DEPTH : (1 << INDEX_W);
	localparam int RIW = $clog2(RN);

	logic [LW-1:0] len_q;
	logic          rsp_vld_q;
	rsp_t          rsp_q;

	word_t         cell_data [DEPTH];
	word_t         low_data  [DEPTH];
	word_t         high_data [DEPTH];
	cell_cmd_t     cell_cmd  [DEPTH];
	word_t         rd_win    [RN];

	logic          fire;
	logic          ok;
	logic          full;
	logic          in_rng;
	logic [CW-1:0] pos_w;
	logic [CW-1:0] len_w;
	logic [LW-1:0] len_d;
	status_t       status_d;
	word_t         result_d;
	word_t         rd_word;

	// Advance when the response slot is empty or being drained this cycle.
	assign req.ready = !rsp_vld_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	assign pos_w  = CW'(req.data.index);
	assign len_w  = CW'(len_q);
	assign full   = (len_q == LW'(DEPTH));
	assign in_rng = (pos_w < len_w);

	// Read window: the cells an index can address.
	for (genvar r = 0; r < RN; r++) begin : g_rd
		assign rd_win[r] = cell_data[r];
	end
	assign rd_word = rd_win[req.data.index[RIW-1:0]];

	// Decode the request: status, returned word and new length.
	always_comb begin
		status_d = ST_OK;
		result_d = '0;
		len_d    = len_q;
		unique case (req.data.func)
			FN_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					len_d = len_q + 1'b1;
				end
			end
			FN_READ: begin
				if (!in_rng) begin
					status_d = ST_INDEX;
				end else begin
					result_d = rd_word;
				end
			end
			FN_INSERT: begin
				priority if (!in_rng) begin
					status_d = ST_INDEX;
				end else if (full) begin
					status_d = ST_FULL;
				end else if (req.data.value == '0) begin
					status_d = ST_ZERO;
				end else begin
					len_d = len_q + 1'b1;
				end
			end
			FN_REMOVE: begin
				if (!in_rng) begin
					status_d = ST_INDEX;
				end else begin
					result_d = rd_word;
					len_d    = len_q - 1'b1;
				end
			end
		endcase
	end

	assign ok = (status_d == ST_OK);

	// Cell chain: each cell holds, loads the new word, takes its lower neighbor (insert
	// shifts the tail up) or its upper neighbor (remove shifts the tail down).
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign low_data[i] = '0;
		end else begin : g_low
			assign low_data[i] = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign high_data[i] = '0;
		end else begin : g_high
			assign high_data[i] = cell_data[i+1];
		end

		always_comb begin
			cell_cmd[i] = CELL_HOLD;
			if (fire && ok) begin
				unique case (req.data.func)
					FN_APPEND: begin
						if (len_w == CW'(i)) cell_cmd[i] = CELL_LOAD;
					end
					FN_READ: cell_cmd[i] = CELL_HOLD;
					FN_INSERT: begin
						if (pos_w == CW'(i)) begin
							cell_cmd[i] = CELL_LOAD;
						end else if (pos_w < CW'(i)) begin
							cell_cmd[i] = CELL_FROM_LOW;
						end
					end
					FN_REMOVE: begin
						if (pos_w <= CW'(i)) cell_cmd[i] = CELL_FROM_HIGH;
					end
				endcase
			end
		end

		ilir_cell u_cell (
			.clk       (clk),
			.cmd       (cell_cmd[i]),
			.load_val  (req.data.value),
			.low_data  (low_data[i]),
			.high_data (high_data[i]),
			.data      (cell_data[i])
		);
	end

	// Length and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (fire) begin
				len_q <= len_d;
			end
			if (fire) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// Response payload; count carries the low bits of the new length.
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.value_out <= result_d;
			rsp_q.status    <= status_d;
			rsp_q.count     <= COUNT_W'(len_d);
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

	`include "assert_macros.svh"

	`ILIR_ASSERT(a_len_bound, clk, arst_n, len_q <= LW'(DEPTH), "length above capacity")
	`ILIR_ASSERT(a_count_match, clk, arst_n, !rsp_vld_q || rsp_q.count == COUNT_W'(len_q), "count differs from length")
	`ILIR_ASSERT_NEXT(a_rsp_after_req, clk, arst_n, fire, rsp_vld_q, "request without response")
	`ILIR_ASSERT_NEXT(a_append_grows, clk, arst_n, fire && ok && req.data.func == FN_APPEND, len_q == LW'($past(len_q) + 1'b1), "append did not grow list")
endmodule
